>>> hdl/tmcf_pkg.sv
package tmcf_pkg;

  // Characters the filter reacts to
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Class of the byte last sent out
  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_COMMA = 2'd1,
    CLS_SPACE = 2'd2
  } emit_class_t;

  // One input request
  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_end;
  } item_t;

  // One result
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } result_t;

  // Results produced by one input item, in order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_t;

endpackage

>>> hdl/tmcf_core.sv
module tmcf_core (
  input  logic            clk,
  input  logic            rst,
  input  tmcf_pkg::item_t item,
  input  logic            advance,
  output tmcf_pkg::step_t step
);

  logic                      inside_tag;
  logic                      after_at_sign;
  logic                      after_dash;
  tmcf_pkg::emit_class_t     last_class;
  logic                      space_held;

  logic                      inside_tag_next;
  logic                      after_at_sign_next;
  logic                      after_dash_next;
  tmcf_pkg::emit_class_t     last_class_next;
  logic                      space_held_next;

  logic [7:0]                c;
  logic                      ws;
  logic [1:0]                n;
  logic [7:0]                b0;
  logic [7:0]                b1;

  assign c  = item.in_byte;
  assign ws = (c == tmcf_pkg::CH_SPACE) || (c >= tmcf_pkg::CH_TAB && c <= tmcf_pkg::CH_CR);

  // Decide the results and next state for the registered item
  always_comb begin
    inside_tag_next    = inside_tag;
    after_at_sign_next = after_at_sign;
    after_dash_next    = after_dash;
    last_class_next    = last_class;
    space_held_next    = space_held;
    n  = 2'd0;
    b0 = tmcf_pkg::CH_SPACE;
    b1 = tmcf_pkg::CH_SPACE;

    // Release or drop a held space on any non-space byte
    if (space_held && c != tmcf_pkg::CH_SPACE) begin
      space_held_next = 1'b0;
      if (c != tmcf_pkg::CH_PERIOD && c != tmcf_pkg::CH_COMMA) begin
        b0 = tmcf_pkg::CH_SPACE;
        n  = 2'd1;
        last_class_next = tmcf_pkg::CLS_SPACE;
      end
    end

    if (c == tmcf_pkg::CH_LT) begin
      inside_tag_next = 1'b1;
    end else if (c == tmcf_pkg::CH_GT) begin
      inside_tag_next = 1'b0;
    end else if (!inside_tag) begin
      if (c == tmcf_pkg::CH_AT) begin
        after_at_sign_next = 1'b1;
      end else if (after_at_sign && ws) begin
        after_at_sign_next = 1'b0;
      end else begin
        after_at_sign_next = 1'b0;
        if (c == tmcf_pkg::CH_DASH) begin
          after_dash_next = 1'b1;
        end else if (after_dash && ws) begin
          // drop whitespace following a dash run
        end else begin
          after_dash_next = 1'b0;
          if (c == tmcf_pkg::CH_SPACE) begin
            if (!space_held_next && last_class_next != tmcf_pkg::CLS_COMMA &&
                last_class_next != tmcf_pkg::CLS_SPACE) begin
              space_held_next = 1'b1;
            end
          end else begin
            if (n == 2'd0) begin
              b0 = c;
            end else begin
              b1 = c;
            end
            n = n + 2'd1;
            last_class_next = (c == tmcf_pkg::CH_COMMA) ? tmcf_pkg::CLS_COMMA
                                                        : tmcf_pkg::CLS_OTHER;
          end
        end
      end
    end

    // Flush a held space at line end, then clear all state
    if (item.line_end) begin
      if (space_held_next) begin
        if (n == 2'd0) begin
          b0 = tmcf_pkg::CH_SPACE;
        end else begin
          b1 = tmcf_pkg::CH_SPACE;
        end
        n = n + 2'd1;
      end
      inside_tag_next    = 1'b0;
      after_at_sign_next = 1'b0;
      after_dash_next    = 1'b0;
      last_class_next    = tmcf_pkg::CLS_OTHER;
      space_held_next    = 1'b0;
    end
  end

  assign step.count              = n;
  assign step.first.out_byte     = b0;
  assign step.first.last_of_run  = (n == 2'd1);
  assign step.second.out_byte    = b1;
  assign step.second.last_of_run = 1'b1;

  // Update the filter state when the item is handed to the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_tag    <= 1'b0;
      after_at_sign <= 1'b0;
      after_dash    <= 1'b0;
      last_class    <= tmcf_pkg::CLS_OTHER;
      space_held    <= 1'b0;
    end else if (advance) begin
      inside_tag    <= inside_tag_next;
      after_at_sign <= after_at_sign_next;
      after_dash    <= after_dash_next;
      last_class    <= last_class_next;
      space_held    <= space_held_next;
    end
  end

endmodule

>>> hdl/tmcf_outq.sv
module tmcf_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tmcf_pkg::step_t   step,
  output logic [1:0]        room,
  output logic              result_valid,
  input  logic              result_stall,
  output tmcf_pkg::result_t result
);

  logic [1:0]         cnt;
  logic [1:0]         cnt_next;
  logic [1:0]         cnt_left;
  logic               pop;
  tmcf_pkg::result_t  q0;
  tmcf_pkg::result_t  q1;
  tmcf_pkg::result_t  q0_next;
  tmcf_pkg::result_t  q1_next;

  assign result_valid = (cnt != 2'd0);
  assign result       = q0;
  assign pop          = result_valid && !result_stall;
  assign cnt_left     = cnt - {1'b0, pop};
  assign room         = 2'd2 - cnt_left;

  // Shift out the head, then append the new results behind what is left
  always_comb begin
    q0_next  = q0;
    q1_next  = q1;
    cnt_next = cnt_left;
    if (pop) begin
      q0_next = q1;
    end
    if (push) begin
      cnt_next = cnt_left + step.count;
      if (step.count != 2'd0) begin
        if (cnt_left == 2'd0) begin
          q0_next = step.first;
        end else begin
          q1_next = step.first;
        end
      end
      if (step.count == 2'd2) begin
        q1_next = step.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    q0 <= q0_next;
    q1 <= q1_next;
  end

endmodule

>>> hdl/text_markup_cleanup_filter.sv
// Text markup cleanup filter. Takes one text byte per request and returns zero,
// one or two cleaned bytes, the final one of each item marked last_of_run.
// Tags from '<' to '>' are removed, and '@' and '-' are removed. The first
// whitespace byte after an '@' is dropped, and after a '-' whitespace is dropped
// until some other byte arrives. Space runs collapse to at most one space;
// a space is held back until the next non-space byte or line end decides it.
// All state clears after an item with line_end set. An item sits in the input
// register, where the filter step runs, and its results then wait in a
// two-entry result queue. The block takes one item per cycle while the result
// side keeps up; an item that yields two results can hold back the next item,
// since results leave through the single result port.
module text_markup_cleanup_filter (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  tmcf_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output tmcf_pkg::result_t result
);

  logic              s1_valid;
  tmcf_pkg::item_t   s1_item;
  tmcf_pkg::step_t   step;
  logic [1:0]        room;
  logic              advance;

  // Hand the item on when the queue can take all its results
  assign advance    = s1_valid && (step.count <= room);
  assign item_stall = s1_valid && !advance;

  // Hold the input register while its item waits for queue room
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      s1_item <= item;
    end
  end

  tmcf_core u_core (
    .clk     (clk),
    .rst     (rst),
    .item    (s1_item),
    .advance (advance),
    .step    (step)
  );

  tmcf_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (advance),
    .step         (step),
    .room         (room),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
